### hw/rtl/ucrh_pkg.sv
// Shared types, request codes and helpers for the USB control request handler.
package ucrh_pkg;

  localparam int EP_COUNT = 7;

  localparam logic [2:0] ACT_ACK        = 3'd0;
  localparam logic [2:0] ACT_DATA       = 3'd1;
  localparam logic [2:0] ACT_STALL      = 3'd2;
  localparam logic [2:0] ACT_DESC       = 3'd3;
  localparam logic [2:0] ACT_GET_REPORT = 3'd4;
  localparam logic [2:0] ACT_SET_REPORT = 3'd5;

  localparam logic [1:0] PHASE_DEFAULT    = 2'd0;
  localparam logic [1:0] PHASE_ADDRESS    = 2'd1;
  localparam logic [1:0] PHASE_CONFIGURED = 2'd2;

  localparam logic [7:0] FEAT_HALT   = 8'h00;
  localparam logic [7:0] FEAT_WAKEUP = 8'h01;

  localparam logic CFG_ENDPOINT_MASK = 1'b0;
  localparam logic CFG_MAX_CONFIG    = 1'b1;

  // {bRequest, bmRequestType}
  localparam logic [15:0] REQ_CLEAR_FEATURE_DEV = 16'h0100;
  localparam logic [15:0] REQ_SET_FEATURE_DEV   = 16'h0300;
  localparam logic [15:0] REQ_CLEAR_FEATURE_EP  = 16'h0102;
  localparam logic [15:0] REQ_SET_FEATURE_EP    = 16'h0302;
  localparam logic [15:0] REQ_GET_CONFIG        = 16'h0880;
  localparam logic [15:0] REQ_GET_DESC_DEV      = 16'h0680;
  localparam logic [15:0] REQ_GET_DESC_IFACE    = 16'h0681;
  localparam logic [15:0] REQ_GET_STATUS_DEV    = 16'h0080;
  localparam logic [15:0] REQ_GET_STATUS_EP     = 16'h0082;
  localparam logic [15:0] REQ_SET_ADDRESS       = 16'h0500;
  localparam logic [15:0] REQ_SET_CONFIG        = 16'h0900;
  localparam logic [15:0] REQ_HID_GET_REPORT    = 16'h01A1;
  localparam logic [15:0] REQ_HID_SET_REPORT    = 16'h0921;
  localparam logic [15:0] REQ_HID_GET_IDLE      = 16'h02A1;
  localparam logic [15:0] REQ_HID_SET_IDLE      = 16'h0A21;
  localparam logic [15:0] REQ_HID_GET_PROTOCOL  = 16'h03A1;
  localparam logic [15:0] REQ_HID_SET_PROTOCOL  = 16'h0B21;

  typedef struct packed {
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] setup_value;
    logic [15:0] setup_index;
    logic [15:0] setup_length;
  } setup_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  reply_count;
    logic [7:0]  reply_first;
    logic [7:0]  reply_second;
    logic        apply_address;
    logic [6:0]  new_address;
    logic        toggle_reset;
    logic [3:0]  toggle_endpoint;
    logic [15:0] forward_value;
    logic [15:0] forward_length;
  } result_t;

  typedef struct packed {
    logic [1:0]          phase;
    logic [7:0]          config_value;
    logic                wakeup;
    logic [EP_COUNT-1:0] halt;
    logic [7:0]          idle_rate;
    logic                protocol;
    logic [6:0]          address;
  } dev_state_t;

  typedef struct packed {
    logic [EP_COUNT-1:0] endpoint_mask;
    logic [7:0]          max_config;
  } cfg_t;

  function automatic logic [1:0] clip_count(input logic [1:0] size, input logic [15:0] len);
    clip_count = (len < {14'd0, size}) ? len[1:0] : size;
  endfunction

endpackage

### hw/rtl/ucrh_setup_if.sv
// Setup packet channel: valid/ready handshake with the five setup fields.
interface ucrh_setup_if;
  logic        valid;
  logic        ready;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] setup_value;
  logic [15:0] setup_index;
  logic [15:0] setup_length;

  modport source (output valid, request_type, request_code, setup_value, setup_index,
                  setup_length, input ready);
  modport sink (input valid, request_type, request_code, setup_value, setup_index,
                setup_length, output ready);
endinterface

### hw/rtl/ucrh_result_if.sv
// Result channel: valid/ready handshake with the decoded response fields.
interface ucrh_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [1:0]  reply_count;
  logic [7:0]  reply_first;
  logic [7:0]  reply_second;
  logic        apply_address;
  logic [6:0]  new_address;
  logic        toggle_reset;
  logic [3:0]  toggle_endpoint;
  logic [15:0] forward_value;
  logic [15:0] forward_length;

  modport source (output valid, action, reply_count, reply_first, reply_second,
                  apply_address, new_address, toggle_reset, toggle_endpoint,
                  forward_value, forward_length, input ready);
  modport sink (input valid, action, reply_count, reply_first, reply_second,
                apply_address, new_address, toggle_reset, toggle_endpoint,
                forward_value, forward_length, output ready);
endinterface

### hw/rtl/ucrh_decode.sv
// Request decoder: maps one setup packet and the device state to a result and next state.
module ucrh_decode import ucrh_pkg::*; (
  input  setup_t     req,
  input  dev_state_t state,
  input  cfg_t       cfg,
  output result_t    res,
  output dev_state_t state_next
);

  logic [15:0] key;
  logic [7:0]  lo;
  logic [3:0]  ep;
  logic        ep_bad;
  logic        ep_on;
  logic [2:0]  act;

  assign key    = {req.request_code, req.request_type};
  assign lo     = req.setup_value[7:0];
  assign ep     = req.setup_index[3:0];
  assign ep_bad = (ep == 4'd0) || ({28'd0, ep} >= EP_COUNT);
  assign ep_on  = ({28'd0, ep} < EP_COUNT) && cfg.endpoint_mask[ep[2:0]];

  always_comb begin
    res        = '0;
    state_next = state;
    act        = ACT_ACK;
    case (key)
      REQ_CLEAR_FEATURE_DEV: begin
        if (lo == FEAT_WAKEUP) state_next.wakeup = 1'b0;
        else act = ACT_STALL;
      end
      REQ_SET_FEATURE_DEV: begin
        if (lo == FEAT_WAKEUP) state_next.wakeup = 1'b1;
        else act = ACT_STALL;
      end
      REQ_CLEAR_FEATURE_EP: begin
        if (lo != FEAT_HALT || ep_bad) begin
          act = ACT_STALL;
        end else if (ep_on) begin
          state_next.halt[ep[2:0]] = 1'b0;
          res.toggle_reset         = 1'b1;
          res.toggle_endpoint      = ep;
        end
      end
      REQ_SET_FEATURE_EP: begin
        if (lo != FEAT_HALT || ep_bad) act = ACT_STALL;
        else if (ep_on) state_next.halt[ep[2:0]] = 1'b1;
      end
      REQ_GET_CONFIG: begin
        if (state.phase == PHASE_ADDRESS || state.phase == PHASE_CONFIGURED) begin
          act             = ACT_DATA;
          res.reply_count = clip_count(2'd1, req.setup_length);
          res.reply_first = (state.phase == PHASE_CONFIGURED) ? state.config_value : 8'd0;
        end else begin
          act = ACT_STALL;
        end
      end
      REQ_GET_DESC_DEV, REQ_GET_DESC_IFACE: begin
        act = ACT_DESC;
      end
      REQ_GET_STATUS_DEV: begin
        act             = ACT_DATA;
        res.reply_count = clip_count(2'd2, req.setup_length);
        res.reply_first = {6'd0, state.wakeup, 1'b0};
      end
      REQ_GET_STATUS_EP: begin
        if ({28'd0, ep} >= EP_COUNT) begin
          act = ACT_STALL;
        end else begin
          act             = ACT_DATA;
          res.reply_count = clip_count(2'd2, req.setup_length);
          res.reply_first = {7'd0, state.halt[ep[2:0]]};
        end
      end
      REQ_SET_ADDRESS: begin
        state_next.address = req.setup_value[6:0];
        state_next.phase   = PHASE_ADDRESS;
        res.apply_address  = 1'b1;
        res.new_address    = state_next.address;
      end
      REQ_SET_CONFIG: begin
        if (lo > cfg.max_config) begin
          act = ACT_STALL;
        end else begin
          state_next.config_value = lo;
          state_next.phase        = (lo != 8'd0) ? PHASE_CONFIGURED : PHASE_ADDRESS;
        end
      end
      REQ_HID_GET_REPORT: begin
        act = ACT_GET_REPORT;
      end
      REQ_HID_SET_REPORT: begin
        act = ACT_SET_REPORT;
      end
      REQ_HID_GET_IDLE: begin
        act             = ACT_DATA;
        res.reply_count = clip_count(2'd1, req.setup_length);
        res.reply_first = state.idle_rate;
      end
      REQ_HID_SET_IDLE: begin
        state_next.idle_rate = req.setup_value[15:8];
      end
      REQ_HID_GET_PROTOCOL: begin
        act             = ACT_DATA;
        res.reply_count = clip_count(2'd1, req.setup_length);
        res.reply_first = {7'd0, state.protocol};
      end
      REQ_HID_SET_PROTOCOL: begin
        state_next.protocol = (lo != 8'd0);
      end
      default: begin
        act = ACT_STALL;
      end
    endcase
    res.action = act;
    if (act == ACT_DESC || act == ACT_GET_REPORT || act == ACT_SET_REPORT) begin
      res.forward_value  = req.setup_value;
      res.forward_length = req.setup_length;
    end
  end

endmodule

### hw/rtl/usb_control_request_handler.sv
// USB control request handler top level: input register, decoder, result register.
//
// Usage:
//   setup  - sink channel; one beat is one 8-byte SETUP packet.
//   result - source channel; one beat per packet: action, reply bytes,
//            address and toggle side effects, forwarded wValue/wLength.
//   cfg_write/cfg_index/cfg_data - register writes: index 0 is the enabled
//            endpoint mask, index 1 the highest accepted configuration.
//            Write only while no packet is in flight.
// Throughput: one packet per cycle; the input register feeds the decoder and
//   the result register, and both stages advance whenever the result stage
//   is empty or its beat is taken.
// Reset (rst, synchronous): both stages empty, device in default state with
//   configuration 0, address 0, no halts, idle rate 0, report protocol, the
//   endpoint mask cleared and the configuration limit at 1.
// Stall: while result.ready is low the result beat holds, the input register
//   fills, and setup.ready drops until the result stage drains.
module usb_control_request_handler import ucrh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  ucrh_setup_if.sink          setup,
  ucrh_result_if.source       result,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);

  logic       in_valid;
  setup_t     in_item;
  logic       out_valid;
  result_t    out_item;
  dev_state_t state;
  dev_state_t state_next;
  result_t    res_next;
  cfg_t       cfg;
  logic       out_free;
  logic       fire;

  assign out_free    = !out_valid || result.ready;
  assign fire        = in_valid && out_free;
  assign setup.ready = !in_valid || out_free;

  ucrh_decode u_decode (
    .req        (in_item),
    .state      (state),
    .cfg        (cfg),
    .res        (res_next),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '{phase: PHASE_DEFAULT, config_value: 8'd0, wakeup: 1'b0,
                     halt: '0, idle_rate: 8'd0, protocol: 1'b1, address: 7'd0};
      cfg       <= '{endpoint_mask: '0, max_config: 8'd1};
    end else begin
      if (setup.ready) begin
        in_valid <= setup.valid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        state <= state_next;
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_ENDPOINT_MASK: cfg.endpoint_mask <= cfg_data[EP_COUNT-1:0];
          CFG_MAX_CONFIG:    cfg.max_config    <= cfg_data;
          default:           cfg               <= cfg;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (setup.ready && setup.valid) begin
      in_item <= '{request_type: setup.request_type, request_code: setup.request_code,
                   setup_value: setup.setup_value, setup_index: setup.setup_index,
                   setup_length: setup.setup_length};
    end
    if (fire) begin
      out_item <= res_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.action          = out_item.action;
  assign result.reply_count     = out_item.reply_count;
  assign result.reply_first     = out_item.reply_first;
  assign result.reply_second    = out_item.reply_second;
  assign result.apply_address   = out_item.apply_address;
  assign result.new_address     = out_item.new_address;
  assign result.toggle_reset    = out_item.toggle_reset;
  assign result.toggle_endpoint = out_item.toggle_endpoint;
  assign result.forward_value   = out_item.forward_value;
  assign result.forward_length  = out_item.forward_length;

endmodule

### tb/usb_control_request_handler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the USB control request handler: directed and random setup beats.
module usb_control_request_handler_tb import ucrh_pkg::*;;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SEGMENT_SIZE = 200;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic       cfg_index;
  logic [7:0] cfg_data;

  ucrh_setup_if  setup_ch ();
  ucrh_result_if result_ch ();

  usb_control_request_handler dut (
    .clk       (clk),
    .rst       (rst),
    .setup     (setup_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  dev_state_t  dev;
  cfg_t        cfg;
  result_t     expected_responses [$];
  logic [15:0] known_req [$];
  int          src_idle_pct  = 0;
  int          sink_idle_pct = 0;
  int          hold_request  = 0;
  int          fail_count    = 0;
  int          reported      = 0;

  function automatic logic [1:0] clipped_count(input logic [1:0] size, input logic [15:0] len);
    return (len < {14'd0, size}) ? len[1:0] : size;
  endfunction

  function automatic result_t predict_response(input setup_t s);
    result_t    r;
    logic [7:0] sel;
    logic [3:0] ep;
    logic       in_range;
    logic       enabled;
    r = '0;
    r.action = ACT_ACK;
    sel = s.setup_value[7:0];
    ep = s.setup_index[3:0];
    in_range = ep < EP_COUNT;
    enabled = in_range && cfg.endpoint_mask[ep[2:0]];
    case ({s.request_code, s.request_type})
      REQ_CLEAR_FEATURE_DEV: begin
        if (sel == FEAT_WAKEUP) dev.wakeup = 1'b0;
        else r.action = ACT_STALL;
      end
      REQ_SET_FEATURE_DEV: begin
        if (sel == FEAT_WAKEUP) dev.wakeup = 1'b1;
        else r.action = ACT_STALL;
      end
      REQ_CLEAR_FEATURE_EP: begin
        if (sel != FEAT_HALT || ep == 4'd0 || !in_range) begin
          r.action = ACT_STALL;
        end else if (enabled) begin
          dev.halt[ep[2:0]] = 1'b0;
          r.toggle_reset = 1'b1;
          r.toggle_endpoint = ep;
        end
      end
      REQ_SET_FEATURE_EP: begin
        if (sel != FEAT_HALT || ep == 4'd0 || !in_range) r.action = ACT_STALL;
        else if (enabled) dev.halt[ep[2:0]] = 1'b1;
      end
      REQ_GET_CONFIG: begin
        if (dev.phase == PHASE_ADDRESS || dev.phase == PHASE_CONFIGURED) begin
          r.action = ACT_DATA;
          r.reply_count = clipped_count(2'd1, s.setup_length);
          r.reply_first = (dev.phase == PHASE_CONFIGURED) ? dev.config_value : 8'd0;
        end else begin
          r.action = ACT_STALL;
        end
      end
      REQ_GET_DESC_DEV, REQ_GET_DESC_IFACE: r.action = ACT_DESC;
      REQ_GET_STATUS_DEV: begin
        r.action = ACT_DATA;
        r.reply_count = clipped_count(2'd2, s.setup_length);
        r.reply_first = dev.wakeup ? 8'h02 : 8'h00;
      end
      REQ_GET_STATUS_EP: begin
        if (!in_range) begin
          r.action = ACT_STALL;
        end else begin
          r.action = ACT_DATA;
          r.reply_count = clipped_count(2'd2, s.setup_length);
          r.reply_first = {7'd0, dev.halt[ep[2:0]]};
        end
      end
      REQ_SET_ADDRESS: begin
        dev.address = s.setup_value[6:0];
        dev.phase = PHASE_ADDRESS;
        r.apply_address = 1'b1;
        r.new_address = s.setup_value[6:0];
      end
      REQ_SET_CONFIG: begin
        if (sel > cfg.max_config) begin
          r.action = ACT_STALL;
        end else begin
          dev.config_value = sel;
          dev.phase = (sel != 8'd0) ? PHASE_CONFIGURED : PHASE_ADDRESS;
        end
      end
      REQ_HID_GET_REPORT: r.action = ACT_GET_REPORT;
      REQ_HID_SET_REPORT: r.action = ACT_SET_REPORT;
      REQ_HID_GET_IDLE: begin
        r.action = ACT_DATA;
        r.reply_count = clipped_count(2'd1, s.setup_length);
        r.reply_first = dev.idle_rate;
      end
      REQ_HID_SET_IDLE: dev.idle_rate = s.setup_value[15:8];
      REQ_HID_GET_PROTOCOL: begin
        r.action = ACT_DATA;
        r.reply_count = clipped_count(2'd1, s.setup_length);
        r.reply_first = {7'd0, dev.protocol};
      end
      REQ_HID_SET_PROTOCOL: dev.protocol = (sel != 8'd0);
      default: r.action = ACT_STALL;
    endcase
    if (r.action >= ACT_DESC) begin
      r.forward_value = s.setup_value;
      r.forward_length = s.setup_length;
    end
    return r;
  endfunction

  function automatic setup_t random_setup();
    setup_t      s;
    logic [15:0] key;
    int          roll;
    roll = $urandom_range(99);
    key = known_req[$urandom_range(known_req.size() - 1)];
    if (roll >= 93) key = 16'($urandom);
    else if (roll >= 85) key[7:0] = key[7:0] ^ (8'd1 << $urandom_range(7));
    s.request_code = key[15:8];
    s.request_type = key[7:0];
    s.setup_value = 16'($urandom);
    case ($urandom_range(5))
      0: s.setup_value[7:0] = FEAT_HALT;
      1: s.setup_value[7:0] = FEAT_WAKEUP;
      2: s.setup_value[7:0] = 8'($urandom_range(3));
      3: s.setup_value[7:0] = cfg.max_config;
      4: s.setup_value[7:0] = cfg.max_config + 8'd1;
      default: ;
    endcase
    s.setup_index = 16'($urandom);
    s.setup_length = ($urandom_range(1) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
    return s;
  endfunction

  task automatic send_setup(input setup_t s);
    bit took;
    while ($urandom_range(99) < src_idle_pct) begin
      setup_ch.valid <= 1'b0;
      @(posedge clk);
    end
    setup_ch.valid        <= 1'b1;
    setup_ch.request_type <= s.request_type;
    setup_ch.request_code <= s.request_code;
    setup_ch.setup_value  <= s.setup_value;
    setup_ch.setup_index  <= s.setup_index;
    setup_ch.setup_length <= s.setup_length;
    do begin
      @(negedge clk);
      took = setup_ch.ready;
      @(posedge clk);
    end while (!took);
    expected_responses.push_back(predict_response(s));
  endtask

  task automatic issue(input logic [15:0] key, input logic [15:0] value,
                       input logic [15:0] index, input logic [15:0] length);
    setup_t s;
    s.request_code = key[15:8];
    s.request_type = key[7:0];
    s.setup_value  = value;
    s.setup_index  = index;
    s.setup_length = length;
    send_setup(s);
  endtask

  task automatic wait_drained();
    setup_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic index, input logic [7:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (index == CFG_ENDPOINT_MASK) cfg.endpoint_mask = data[EP_COUNT-1:0];
    else cfg.max_config = data;
  endtask

  task automatic apply_settings(input logic [7:0] mask, input logic [7:0] max_config);
    wait_drained();
    write_register(CFG_ENDPOINT_MASK, mask);
    write_register(CFG_MAX_CONFIG, max_config);
  endtask

  task automatic test_default_state();
    issue(REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'h0001);
    issue(REQ_GET_STATUS_DEV, 16'h0000, 16'h0000, 16'hFFFF);
    issue(REQ_SET_CONFIG, 16'hFF01, 16'h0000, 16'h0000);
    issue(REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'h0000);
    issue(REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'h0001);
    wait_drained();
  endtask

  task automatic test_device_requests();
    issue(REQ_SET_FEATURE_DEV, 16'hFF01, 16'hFFFF, 16'h0000);
    issue(REQ_GET_STATUS_DEV, 16'h0000, 16'h0000, 16'h0001);
    issue(REQ_CLEAR_FEATURE_DEV, 16'h0002, 16'h0000, 16'h0000);
    issue(REQ_SET_ADDRESS, 16'h0000, 16'h0000, 16'h0000);
    issue(REQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(REQ_SET_CONFIG, 16'h0002, 16'h0000, 16'h0000);
    wait_drained();
  endtask

  task automatic test_endpoint_halt();
    apply_settings(8'b1010_1010, 8'hFF);
    issue(REQ_SET_FEATURE_EP, 16'h0000, 16'h0000, 16'h0000);
    issue(REQ_SET_FEATURE_EP, 16'hFF00, 16'hFFF3, 16'h0000);
    issue(REQ_GET_STATUS_EP, 16'h0000, 16'h0003, 16'h0002);
    issue(REQ_SET_FEATURE_EP, 16'h0000, 16'h0002, 16'h0000);
    issue(REQ_SET_FEATURE_EP, 16'h0000, 16'h0009, 16'h0000);
    issue(REQ_GET_STATUS_EP, 16'h0000, 16'h000F, 16'h0002);
    issue(REQ_CLEAR_FEATURE_EP, 16'h0000, 16'h0003, 16'h0000);
    issue(REQ_CLEAR_FEATURE_EP, 16'h0001, 16'h0005, 16'h0000);
    wait_drained();
  endtask

  task automatic test_hid_requests();
    issue(REQ_HID_SET_IDLE, 16'hA5FF, 16'h0000, 16'h0000);
    issue(REQ_HID_GET_IDLE, 16'h0000, 16'h0000, 16'hFFFF);
    issue(REQ_HID_SET_PROTOCOL, 16'hFF00, 16'h0000, 16'h0000);
    issue(REQ_HID_GET_PROTOCOL, 16'h0000, 16'h0000, 16'h0001);
    issue(REQ_HID_GET_REPORT, 16'hFFFF, 16'h0000, 16'hFFFF);
    issue(REQ_HID_SET_REPORT, 16'h0201, 16'h0001, 16'h0040);
    issue(REQ_GET_DESC_DEV, 16'h0100, 16'h0000, 16'h0012);
    issue(REQ_GET_DESC_IFACE, 16'h2200, 16'h0000, 16'hFFFF);
    issue(16'hFFFF, 16'h0000, 16'h0000, 16'h0002);
    wait_drained();
  endtask

  task automatic test_result_backpressure();
    int saved_src;
    saved_src = src_idle_pct;
    src_idle_pct = 0;
    @(negedge clk);
    hold_request = 150;
    @(posedge clk);
    repeat (10) send_setup(random_setup());
    src_idle_pct = saved_src;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int seg = 0; seg < 6; seg++) begin
      src_idle_pct  = (seg < 2) ? 37 : (seg < 4) ? 68 : 0;
      sink_idle_pct = (seg < 2) ? 68 : (seg < 4) ? 37 : 0;
      case (seg)
        0: apply_settings(8'hFF, 8'hFF);
        1: apply_settings(8'h00, 8'h00);
        2: apply_settings(8'($urandom), 8'($urandom_range(4)));
        3: apply_settings(8'h7F, 8'h01);
        4: apply_settings(8'($urandom), 8'($urandom));
        default: apply_settings(8'($urandom), 8'h02);
      endcase
      repeat (SEGMENT_SIZE) send_setup(random_setup());
    end
    wait_drained();
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    result_t got;
    result_t want;
    forever begin
      @(negedge clk);
      if (result_ch.valid && result_ch.ready) begin
        got.action          = result_ch.action;
        got.reply_count     = result_ch.reply_count;
        got.reply_first     = result_ch.reply_first;
        got.reply_second    = result_ch.reply_second;
        got.apply_address   = result_ch.apply_address;
        got.new_address     = result_ch.new_address;
        got.toggle_reset    = result_ch.toggle_reset;
        got.toggle_endpoint = result_ch.toggle_endpoint;
        got.forward_value   = result_ch.forward_value;
        got.forward_length  = result_ch.forward_length;
        if (expected_responses.size() == 0) begin
          fail_count++;
          if (reported++ < 10) $display("unexpected result beat: action %0d", got.action);
        end else begin
          want = expected_responses.pop_front();
          if (got !== want) begin
            fail_count++;
            if (reported++ < 10) begin
              $display("mismatch exp: act %0d cnt %0d b0 %h b1 %h addr %b/%h tog %b/%h fwd %h/%h",
                       want.action, want.reply_count, want.reply_first, want.reply_second,
                       want.apply_address, want.new_address, want.toggle_reset,
                       want.toggle_endpoint, want.forward_value, want.forward_length);
              $display("         got: act %0d cnt %0d b0 %h b1 %h addr %b/%h tog %b/%h fwd %h/%h",
                       got.action, got.reply_count, got.reply_first, got.reply_second,
                       got.apply_address, got.new_address, got.toggle_reset,
                       got.toggle_endpoint, got.forward_value, got.forward_length);
            end
          end
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if ((setup_ch.valid && setup_ch.ready) || (result_ch.valid && result_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst                   <= 1'b1;
    cfg_write             <= 1'b0;
    cfg_index             <= CFG_ENDPOINT_MASK;
    cfg_data              <= 8'd0;
    setup_ch.valid        <= 1'b0;
    setup_ch.request_type <= 8'd0;
    setup_ch.request_code <= 8'd0;
    setup_ch.setup_value  <= 16'd0;
    setup_ch.setup_index  <= 16'd0;
    setup_ch.setup_length <= 16'd0;
    dev = '0;
    dev.phase = PHASE_DEFAULT;
    dev.protocol = 1'b1;
    cfg.endpoint_mask = '0;
    cfg.max_config = 8'd1;
    known_req = '{REQ_CLEAR_FEATURE_DEV, REQ_SET_FEATURE_DEV, REQ_CLEAR_FEATURE_EP,
                  REQ_SET_FEATURE_EP, REQ_GET_CONFIG, REQ_GET_DESC_DEV, REQ_GET_DESC_IFACE,
                  REQ_GET_STATUS_DEV, REQ_GET_STATUS_EP, REQ_SET_ADDRESS, REQ_SET_CONFIG,
                  REQ_HID_GET_REPORT, REQ_HID_SET_REPORT, REQ_HID_GET_IDLE,
                  REQ_HID_SET_IDLE, REQ_HID_GET_PROTOCOL, REQ_HID_SET_PROTOCOL};
    src_idle_pct  = 37;
    sink_idle_pct = 68;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_state();
    test_device_requests();
    test_endpoint_halt();
    test_hid_requests();
    test_result_backpressure();
    test_random_traffic();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
